/* rtl/bfr_pkg.sv */
// shared constants, types and a helper function for the bitmap font text renderer
// no dependencies; compiled first

package bfr_pkg;

   // default geometry, handed to the top level parameters
   localparam int GLYPH_COUNT_DEF   = 8836;
   localparam int SCREEN_WIDTH_DEF  = 640;
   localparam int SCREEN_HEIGHT_DEF = 480;

   // payload widths
   localparam int MODE_W   = 1;
   localparam int ROWIDX_W = 18;
   localparam int ROW_W    = 16;
   localparam int CODE_W   = 8;
   localparam int OFF_W    = 19;
   localparam int COLOR_W  = 8;

   // cursor and geometry widths
   localparam int CX_W     = 11;
   localparam int CY_W     = 10;
   localparam int CHARS_W  = 7;
   localparam int SX_W     = 10;
   localparam int SY_W     = 9;
   localparam int GEOM_W   = 12;
   localparam int PROD_W   = CY_W + GEOM_W;
   localparam int GLYPH_W  = 14;
   localparam int GCMP_W   = 15;
   localparam int ROWSEL_W = 4;

   // code ranges and glyph layout
   localparam logic [CODE_W-1:0]   CODE_BASE     = 8'hA1;
   localparam logic [CODE_W-1:0]   CODE_TOP      = 8'hFE;
   localparam logic [CODE_W-1:0]   CODE_TERM     = 8'h00;
   localparam logic [GCMP_W-1:0]   CODES_PER_ROW = 15'd94;
   localparam logic [ROWSEL_W-1:0] LAST_ROW      = 4'd15;
   localparam logic [CX_W-1:0]     CHAR_STEP_X   = 11'd16;
   localparam logic [CX_W-1:0]     LINE_STEP_Y   = 11'd16;
   localparam logic [CX_W-1:0]     CY_LIMIT      = 11'h3FF;

   // input modes
   localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
   localparam logic [MODE_W-1:0] MODE_DRAW = 1'b1;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_DRAW_COLOR     = 2'd0;
   localparam logic [1:0] REG_START_X        = 2'd1;
   localparam logic [1:0] REG_START_Y        = 2'd2;
   localparam logic [1:0] REG_CHARS_PER_LINE = 2'd3;

   localparam logic [COLOR_W-1:0] DRAW_COLOR_RST     = 8'd15;
   localparam logic [SX_W-1:0]    START_X_RST        = 10'd0;
   localparam logic [SY_W-1:0]    START_Y_RST        = 9'd0;
   localparam logic [CHARS_W-1:0] CHARS_PER_LINE_RST = 7'd40;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BASE,
      ST_ROWS
   } bfr_state_type;

   // control of the shared offset adder
   typedef struct packed {
      logic load_base;
      logic step;
   } bfr_acc_ctrl_type;

   // font rows are stored leftmost pixel in the msb, the mask wants it in bit 0
   function automatic logic [ROW_W-1:0] mirror_row(input logic [ROW_W-1:0] v);
      logic [ROW_W-1:0] r;
      for (int i = 0; i < ROW_W; i++) begin
         r[i] = v[ROW_W-1-i];
      end
      return r;
   endfunction

endpackage

/* rtl/bfr_req_if.sv */
// input channel of the renderer: valid/ready plus load and draw fields
// depends on bfr_pkg

interface bfr_req_if import bfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ROWIDX_W-1:0] font_row_index;
   logic [ROW_W-1:0]    font_row_bits;
   logic [CODE_W-1:0]   code_first;
   logic [CODE_W-1:0]   code_second;

   modport source (
      output valid, mode, font_row_index, font_row_bits, code_first, code_second,
      input  ready
   );
   modport sink (
      input  valid, mode, font_row_index, font_row_bits, code_first, code_second,
      output ready
   );
endinterface

/* rtl/bfr_rsp_if.sv */
// result channel of the renderer: one masked framebuffer row write per transaction
// depends on bfr_pkg

interface bfr_rsp_if import bfr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OFF_W-1:0]   pixel_offset;
   logic [ROW_W-1:0]   pixel_mask;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_row;

   modport source (
      output valid, pixel_offset, pixel_mask, pixel_color, last_row,
      input  ready
   );
   modport sink (
      input  valid, pixel_offset, pixel_mask, pixel_color, last_row,
      output ready
   );
endinterface

/* rtl/bfr_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module bfr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bfr_acc_unit.sv */
// shared offset adder: forms y*width+x once per glyph, then steps one line per row
// depends on bfr_pkg

module bfr_acc_unit import bfr_pkg::*; #(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
   input  logic             clock,
   input  bfr_acc_ctrl_type ctrl,
   input  logic [OFF_W-1:0] prod,
   input  logic [CX_W-1:0]  base_x,
   output logic [OFF_W-1:0] acc
);

   logic [OFF_W-1:0] acc_ff;
   logic [OFF_W-1:0] acc_in;
   logic [OFF_W-1:0] opa;
   logic [OFF_W-1:0] opb;

   // one adder, operands picked by the sequencer
   always_comb begin
      opa    = ctrl.load_base ? prod : acc_ff;
      opb    = ctrl.load_base ? OFF_W'(base_x) : OFF_W'(SCREEN_WIDTH);
      acc_in = opa + opb;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_base || ctrl.step) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* rtl/bitmap_font_text_renderer.sv */
// top level of the bitmap font text renderer: sequencer, cursor, font store, output stage
// depends on bfr_pkg, bfr_req_if, bfr_rsp_if, bfr_ram, bfr_acc_unit

// A load transaction (mode 0) writes one 16-pixel font row; indexes at or beyond
// GLYPH_COUNT*16 are dropped. A draw transaction (mode 1) carries a two-byte code: a zero
// byte homes the cursor, a valid code inside the font draws its glyph on screen as 16 row
// writes (offset, mirrored mask, colour, last_row on the sixteenth), and any other code on
// screen only advances the cursor by 16 pixels. For a drawn character, a check state
// checks wrap and bottom of screen and forms the glyph index and y*SCREEN_WIDTH, a base
// state has the shared adder add the x position, then a row state reads one font row and
// adds one line offset per cycle unless the output stalls; the single font store read port
// and the shared offset adder set this pace. Other draw codes return to idle from the check
// state. Rows drain through the store's read register and an output register, so a stalled
// result side only slows the row state; a new transaction is taken once all reads of the
// previous glyph are issued. The font store has no reset: a row must be loaded before a
// glyph that uses it is drawn. Registers (4 bytes apart): draw_color, start_x, start_y,
// chars_per_line; new start values apply at the next terminator, start_x also at a wrap.

module bitmap_font_text_renderer import bfr_pkg::*; #(
   parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF,
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bfr_req_if.sink               req_bus,
   bfr_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int STORE_ROWS = GLYPH_COUNT * 16;
   localparam int ADDR_W     = $clog2(STORE_ROWS);

   // ---------------------------------------------------------------- registers
   logic [COLOR_W-1:0] draw_color_ff;
   logic [SX_W-1:0]    start_x_ff;
   logic [SY_W-1:0]    start_y_ff;
   logic [CHARS_W-1:0] chars_per_line_ff;
   logic               csr_wr;
   logic [1:0]         csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_color_ff     <= DRAW_COLOR_RST;
         start_x_ff        <= START_X_RST;
         start_y_ff        <= START_Y_RST;
         chars_per_line_ff <= CHARS_PER_LINE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DRAW_COLOR:     draw_color_ff     <= pwdata[COLOR_W-1:0];
            REG_START_X:        start_x_ff        <= pwdata[SX_W-1:0];
            REG_START_Y:        start_y_ff        <= pwdata[SY_W-1:0];
            REG_CHARS_PER_LINE: chars_per_line_ff <= pwdata[CHARS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DRAW_COLOR:     prdata = CSR_DATA_W'(draw_color_ff);
         REG_START_X:        prdata = CSR_DATA_W'(start_x_ff);
         REG_START_Y:        prdata = CSR_DATA_W'(start_y_ff);
         REG_CHARS_PER_LINE: prdata = CSR_DATA_W'(chars_per_line_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- state
   bfr_state_type      state_ff, state_in;
   logic [CX_W-1:0]    cursor_x_ff, cursor_x_in;
   logic [CY_W-1:0]    cursor_y_ff, cursor_y_in;
   logic [CHARS_W-1:0] chars_ff, chars_in;
   logic               off_screen_ff, off_screen_in;

   // latched draw codes and per-glyph values
   logic [CODE_W-1:0]   code_first_ff;
   logic [CODE_W-1:0]   code_second_ff;
   logic [GLYPH_W-1:0]  glyph_ff;
   logic [OFF_W-1:0]    prod_ff;
   logic [ROWSEL_W-1:0] row_ff;

   // read stage (aligned with the store's read register) and output stage
   logic               s1_vld_ff, s1_vld_in;
   logic [OFF_W-1:0]   s1_off_ff;
   logic               s1_last_ff;
   logic               out_vld_ff, out_vld_in;
   logic [OFF_W-1:0]   out_off_ff;
   logic [ROW_W-1:0]   out_mask_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_last_ff;

   logic               req_acc;
   logic               out_free;
   logic               rd_issue;
   logic [ROW_W-1:0]   rd_data;
   logic [OFF_W-1:0]   acc;
   bfr_acc_ctrl_type   acc_ctrl;

   // check-stage decode
   logic               term;
   logic               wrap;
   logic [CX_W-1:0]    y_plus;
   logic               y_ovf;
   logic [CY_W-1:0]    y_new;
   logic               below;
   logic [CX_W-1:0]    x_new;
   logic               codes_ok;
   logic [GCMP_W-1:0]  glyph_full;
   logic               glyph_ok;
   logic               draw_go;
   logic [OFF_W-1:0]   prod_in;

   assign req_acc  = req_bus.valid && req_bus.ready;
   assign out_free = !out_vld_ff || rsp_bus.ready;
   assign rd_issue = (state_ff == ST_ROWS) && (!s1_vld_ff || out_free);

   always_comb begin
      term     = (code_first_ff == CODE_TERM) || (code_second_ff == CODE_TERM);
      wrap     = chars_ff >= chars_per_line_ff;
      y_plus   = CX_W'(cursor_y_ff) + LINE_STEP_Y;
      y_ovf    = wrap && (y_plus > CY_LIMIT);
      y_new    = wrap ? y_plus[CY_W-1:0] : cursor_y_ff;
      below    = GEOM_W'(y_new) >= GEOM_W'(SCREEN_HEIGHT);
      x_new    = wrap ? CX_W'(start_x_ff) : cursor_x_ff;
      codes_ok = (code_first_ff inside {[CODE_BASE:CODE_TOP]}) &&
                 (code_second_ff inside {[CODE_BASE:CODE_TOP]});
      // row-major code table: 94 codes per first byte
      glyph_full = CODES_PER_ROW * GCMP_W'(code_first_ff - CODE_BASE) +
                   GCMP_W'(code_second_ff - CODE_BASE);
      glyph_ok = codes_ok && (glyph_full < GCMP_W'(GLYPH_COUNT));
      draw_go  = !term && !off_screen_ff && !y_ovf && !below && glyph_ok;
      prod_in  = OFF_W'(PROD_W'(y_new) * PROD_W'(SCREEN_WIDTH));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_bus.mode == MODE_DRAW)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = draw_go ? ST_BASE : ST_IDLE;
         ST_BASE:  state_in = ST_ROWS;
         ST_ROWS: begin
            if (rd_issue && (row_ff == LAST_ROW)) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: cursor updates, adder control, pipeline valids
   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      chars_in      = chars_ff;
      off_screen_in = off_screen_ff;
      acc_ctrl      = '0;
      case (state_ff)
         ST_CHECK: begin
            if (term) begin
               cursor_x_in   = CX_W'(start_x_ff);
               cursor_y_in   = CY_W'(start_y_ff);
               chars_in      = '0;
               off_screen_in = 1'b0;
            end else if (off_screen_ff) begin
               // frozen until a terminator
            end else if (y_ovf) begin
               // wrap past the cursor range
               chars_in      = '0;
               cursor_x_in   = CX_W'(start_x_ff);
               off_screen_in = 1'b1;
            end else if (below) begin
               cursor_y_in   = y_new;
               cursor_x_in   = x_new;
               chars_in      = wrap ? '0 : chars_ff;
               off_screen_in = 1'b1;
            end else begin
               cursor_y_in = y_new;
               cursor_x_in = glyph_ok ? x_new : x_new + CHAR_STEP_X;
               chars_in    = (wrap ? '0 : chars_ff) + CHARS_W'(1);
            end
         end
         ST_BASE: begin
            acc_ctrl.load_base = 1'b1;
            cursor_x_in        = cursor_x_ff + CHAR_STEP_X;
         end
         ST_ROWS: begin
            acc_ctrl.step = rd_issue;
         end
         default: ;
      endcase

      s1_vld_in  = (!s1_vld_ff || out_free) ? rd_issue : s1_vld_ff;
      out_vld_in = out_free ? s1_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_x_ff   <= CX_W'(START_X_RST);
         cursor_y_ff   <= CY_W'(START_Y_RST);
         chars_ff      <= '0;
         off_screen_ff <= 1'b0;
         s1_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         chars_ff      <= chars_in;
         off_screen_ff <= off_screen_in;
         s1_vld_ff     <= s1_vld_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         code_first_ff  <= req_bus.code_first;
         code_second_ff <= req_bus.code_second;
      end
      if (state_ff == ST_CHECK) begin
         glyph_ff <= glyph_full[GLYPH_W-1:0];
         prod_ff  <= prod_in;
         row_ff   <= '0;
      end else if (rd_issue) begin
         row_ff <= row_ff + ROWSEL_W'(1);
      end
      if (rd_issue) begin
         s1_off_ff  <= acc;
         s1_last_ff <= (row_ff == LAST_ROW);
      end
      if (out_free && s1_vld_ff) begin
         out_off_ff   <= s1_off_ff;
         out_mask_ff  <= mirror_row(rd_data);
         out_color_ff <= draw_color_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   // no transaction is taken while reset is held
   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.pixel_offset = out_off_ff;
   assign rsp_bus.pixel_mask   = out_mask_ff;
   assign rsp_bus.pixel_color  = out_color_ff;
   assign rsp_bus.last_row     = out_last_ff;

   // ---------------------------------------------------------------- font store
   logic              font_wr;
   logic [ADDR_W-1:0] rd_addr;

   assign font_wr = req_acc && (req_bus.mode == MODE_LOAD) &&
                    (OFF_W'(req_bus.font_row_index) < OFF_W'(STORE_ROWS));
   assign rd_addr = ADDR_W'({glyph_ff, row_ff});

   bfr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (STORE_ROWS)
   ) u_font_store (
      .clock   (clock),
      .wr_en   (font_wr),
      .wr_addr (req_bus.font_row_index[ADDR_W-1:0]),
      .wr_data (req_bus.font_row_bits),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bfr_acc_unit #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_acc_unit (
      .clock  (clock),
      .ctrl   (acc_ctrl),
      .prod   (prod_ff),
      .base_x (cursor_x_ff),
      .acc    (acc)
   );

`ifndef ASSERT_OFF
   // a row waiting on a stalled output stage keeps its offset
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !out_free |=> s1_vld_ff && $stable(s1_off_ff))
      else $error("read stage lost or changed a stalled row");

   // the row read in a cycle is flagged last exactly when it is row fifteen
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rd_issue |=> s1_vld_ff && (s1_last_ff == ($past(row_ff) == LAST_ROW)))
      else $error("last row flag out of step with row counter");

   // bottom of screen is sticky until a terminator
   a_off_sticky: assert property (@(posedge clock) disable iff (reset)
      off_screen_ff && !((state_ff == ST_CHECK) && term) |=> off_screen_ff)
      else $error("off screen cleared without terminator");

   // first row offset is the line product plus the cursor column
   a_base_off: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BASE |=> acc == $past(prod_ff) + OFF_W'($past(cursor_x_ff)))
      else $error("glyph base offset wrong");
`endif

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the bitmap font text renderer: loads glyph rows, draws
// character codes under several register settings and checks every row write it emits
// depends on bfr_pkg, bfr_req_if, bfr_rsp_if and the bitmap_font_text_renderer rtl

module tb_top;
   import bfr_pkg::*;

   localparam int ROWS_PER_GLYPH = 16;
   localparam int STORE_ROWS     = GLYPH_COUNT_DEF * ROWS_PER_GLYPH;
   localparam int CY_MAX         = 1023;     // top of the 10-bit cursor line range
   localparam int SETTLE_CYCLES  = 40;       // one glyph plus its drain, with margin
   localparam int CYCLE_LIMIT    = 200000;
   localparam int IDLE_PCT       = 31;

   // one input transaction, as the driver puts it on the bus
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [ROWIDX_W-1:0] row_index;
      logic [ROW_W-1:0]    row_bits;
      logic [CODE_W-1:0]   first;
      logic [CODE_W-1:0]   second;
   } text_req_type;

   // one masked framebuffer row write
   typedef struct packed {
      logic [OFF_W-1:0]   offset;
      logic [ROW_W-1:0]   mask;
      logic [COLOR_W-1:0] color;
      logic               last;
   } row_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bfr_req_if req_bus ();
   bfr_rsp_if rsp_bus ();

   bitmap_font_text_renderer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #10 clock = ~clock;

   // stimulus waiting for the driver, and row writes the renderer still owes us
   text_req_type  pending_reqs[$];
   row_write_type owed_writes[$];
   int unsigned drawable_glyphs[$];   // glyphs whose sixteen rows have all been loaded

   bit steady = 1'b0;                 // set for the phase that runs without idling
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   // shadow of the renderer: font rows, registers and text cursor
   bit   [ROW_W-1:0]   font_rows [STORE_ROWS];
   logic [COLOR_W-1:0] shadow_color    = DRAW_COLOR_RST;
   logic [SX_W-1:0]    shadow_start_x  = START_X_RST;
   logic [SY_W-1:0]    shadow_start_y  = START_Y_RST;
   logic [CHARS_W-1:0] shadow_per_line = CHARS_PER_LINE_RST;
   logic [CX_W-1:0]    cursor_x;
   logic [CY_W-1:0]    cursor_y;
   logic [CHARS_W-1:0] chars_in_line;
   bit                 past_bottom;

   text_req_type  bus_req;
   text_req_type  next_req;
   row_write_type seen_write;
   row_write_type want_write;

   // ---------------------------------------------------------------------------
   // renderer prediction
   // ---------------------------------------------------------------------------

   function automatic void home_cursor();
      cursor_x      = {1'b0, shadow_start_x};
      cursor_y      = {1'b0, shadow_start_y};
      chars_in_line = '0;
      past_bottom   = 1'b0;
   endfunction

   function automatic bit code_in_range(logic [CODE_W-1:0] b);
      return b >= CODE_BASE && b <= CODE_TOP;
   endfunction

   // apply one accepted transaction to the shadow and queue the row writes it owes
   function automatic void render_request(text_req_type t);
      row_write_type w;
      int unsigned   glyph;
      if (t.mode == MODE_LOAD) begin
         // out-of-range rows are silently dropped
         if (t.row_index < STORE_ROWS) font_rows[t.row_index] = t.row_bits;
         return;
      end
      if (t.first == CODE_TERM || t.second == CODE_TERM) begin
         home_cursor();
         return;
      end
      // below the screen: nothing changes until the next terminator
      if (past_bottom) return;
      // line wrap happens before the character, not after
      if (chars_in_line >= shadow_per_line) begin
         chars_in_line = '0;
         cursor_x = {1'b0, shadow_start_x};
         if (int'(cursor_y) + ROWS_PER_GLYPH > CY_MAX) begin
            past_bottom = 1'b1;
            return;
         end
         cursor_y = cursor_y + CY_W'(ROWS_PER_GLYPH);
      end
      if (cursor_y >= SCREEN_HEIGHT_DEF) begin
         past_bottom = 1'b1;
         return;
      end
      chars_in_line = chars_in_line + 1'b1;
      if (code_in_range(t.first) && code_in_range(t.second)) begin
         glyph = int'(CODES_PER_ROW) * (int'(t.first) - int'(CODE_BASE))
                 + (int'(t.second) - int'(CODE_BASE));
         if (glyph < GLYPH_COUNT_DEF) begin
            for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
               w.offset = OFF_W'((int'(cursor_y) + r) * SCREEN_WIDTH_DEF + int'(cursor_x));
               // leftmost pixel sits in the row msb but in mask bit 0
               for (int i = 0; i < ROW_W; i++) begin
                  w.mask[i] = font_rows[glyph * ROWS_PER_GLYPH + r][ROW_W-1-i];
               end
               w.color = shadow_color;
               w.last  = (r == ROWS_PER_GLYPH - 1);
               owed_writes.push_back(w);
            end
         end
      end
      // invalid codes still move the cursor
      cursor_x = cursor_x + CX_W'(ROWS_PER_GLYPH);
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------

   function automatic void push_load(int unsigned index, logic [ROW_W-1:0] bits);
      text_req_type t;
      t.mode      = MODE_LOAD;
      t.row_index = ROWIDX_W'(index);
      t.row_bits  = bits;
      t.first     = CODE_W'($urandom);     // code fields are don't-care for a load
      t.second    = CODE_W'($urandom);
      pending_reqs.push_back(t);
   endfunction

   function automatic void push_draw(logic [CODE_W-1:0] first, logic [CODE_W-1:0] second);
      text_req_type t;
      t.mode      = MODE_DRAW;
      t.row_index = ROWIDX_W'($urandom);   // load fields are don't-care for a draw
      t.row_bits  = ROW_W'($urandom);
      t.first     = first;
      t.second    = second;
      pending_reqs.push_back(t);
   endfunction

   function automatic void push_glyph(int unsigned glyph);
      push_draw(CODE_BASE + CODE_W'(glyph / int'(CODES_PER_ROW)),
                CODE_BASE + CODE_W'(glyph % int'(CODES_PER_ROW)));
   endfunction

   // row patterns lean on all-clear and all-set now and then
   function automatic logic [ROW_W-1:0] random_row_bits();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return ROW_W'($urandom);
      endcase
   endfunction

   // a nonzero byte outside the code range
   function automatic logic [CODE_W-1:0] stray_code();
      if ($urandom_range(3) == 0) return 8'hFF;
      return CODE_W'($urandom_range(int'(CODE_BASE) - 1, 1));
   endfunction

   function automatic logic [CODE_W-1:0] good_code();
      return CODE_W'($urandom_range(int'(CODE_TOP), int'(CODE_BASE)));
   endfunction

   function automatic void load_glyph(int unsigned glyph);
      for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
         push_load(glyph * ROWS_PER_GLYPH + r, random_row_bits());
      end
      drawable_glyphs.push_back(glyph);
   endfunction

   // mostly well-formed text over loaded glyphs, with terminators, bad codes and stray loads
   function automatic void queue_random_text(int unsigned count, int unsigned term_pct);
      int unsigned made;
      int unsigned pick;
      int unsigned g;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         g = drawable_glyphs[$urandom_range(drawable_glyphs.size() - 1)];
         if (pick < 4) begin
            load_glyph($urandom_range(GLYPH_COUNT_DEF - 1));
            made += ROWS_PER_GLYPH;
         end else begin
            if (pick < 4 + term_pct) begin
               if ($urandom_range(1)) push_draw(CODE_TERM, CODE_W'($urandom));
               else push_draw(CODE_W'($urandom), CODE_TERM);
            end else if (pick < 75) begin
               push_glyph(g);
            end else if (pick < 85) begin
               case ($urandom_range(2))
                  0: push_draw(stray_code(), good_code());
                  1: push_draw(good_code(), stray_code());
                  default: push_draw(stray_code(), stray_code());
               endcase
            end else if (pick < 93) begin
               // anywhere in the 18-bit index space, past-the-end rows included
               push_load($urandom_range((1 << ROWIDX_W) - 1), random_row_bits());
            end else begin
               push_load(g * ROWS_PER_GLYPH + $urandom_range(ROWS_PER_GLYPH - 1),
                         random_row_bits());
            end
            made++;
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // configuration port and phase control
   // ---------------------------------------------------------------------------

   task automatic csr_write(logic [1:0] reg_id, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_id, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      // the register takes the value at this edge
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (reg_id)
         REG_DRAW_COLOR:     shadow_color    = value[COLOR_W-1:0];
         REG_START_X:        shadow_start_x  = value[SX_W-1:0];
         REG_START_Y:        shadow_start_y  = value[SY_W-1:0];
         REG_CHARS_PER_LINE: shadow_per_line = value[CHARS_W-1:0];
         default: ;
      endcase
   endtask

   // wait for every transaction to go in and every row write to come out, then let the
   // renderer finish any work that owes no result
   task automatic drain_and_settle();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || owed_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned color, int unsigned sx, int unsigned sy,
                            int unsigned per_line, int unsigned count,
                            int unsigned term_pct, bit calm);
      drain_and_settle();
      csr_write(REG_DRAW_COLOR, color);
      csr_write(REG_START_X, sx);
      csr_write(REG_START_Y, sy);
      csr_write(REG_CHARS_PER_LINE, per_line);
      steady = calm;
      // a terminator first, so the new start position applies
      push_draw(CODE_TERM, CODE_TERM);
      queue_random_text(count, term_pct);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.mode           = MODE_LOAD;
      req_bus.font_row_index = '0;
      req_bus.font_row_bits  = '0;
      req_bus.code_first     = '0;
      req_bus.code_second    = '0;
      rsp_bus.ready          = 1'b0;
      home_cursor();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // font for the directed part: first glyph with edge patterns, last glyph random
      push_load(0, 16'hFFFF);
      push_load(1, 16'h0000);
      push_load(2, 16'h8000);
      push_load(3, 16'h0001);
      for (int r = 4; r < ROWS_PER_GLYPH; r++) push_load(r, 16'h8000 >> r);
      drawable_glyphs.push_back(0);
      load_glyph(GLYPH_COUNT_DEF - 1);
      // first glyph of the last code row, for the top first byte with the lowest second
      load_glyph(GLYPH_COUNT_DEF - int'(CODES_PER_ROW));

      // directed draws under reset register values
      push_draw(CODE_BASE, CODE_BASE);              // first glyph of the font
      push_draw(CODE_TOP, CODE_TOP);                // last glyph of the font
      push_draw(CODE_BASE - 1'b1, CODE_BASE);       // first byte just below the range
      push_draw(CODE_BASE, 8'hFF);                  // second byte above the range
      push_draw(8'hFF, CODE_TOP);
      push_draw(8'h01, 8'h80);                      // both bytes low but nonzero
      push_draw(CODE_TERM, CODE_BASE);              // terminator in the first byte
      push_draw(CODE_BASE, CODE_BASE);
      push_draw(CODE_BASE, CODE_TERM);              // terminator in the second byte
      push_draw(CODE_TERM, CODE_TERM);
      push_load(STORE_ROWS, 16'hFFFF);              // first row index past the store
      push_load((1 << ROWIDX_W) - 1, 16'hFFFF);     // largest row index
      push_draw(CODE_TOP, CODE_TOP);
      push_draw(CODE_TOP, CODE_BASE);
      queue_random_text(30, 5);

      // register settings, extremes first
      run_phase(0, 0, 0, 1, 70, 1, 1'b0);           // wrap on every character
      run_phase(255, 1023, 511, 64, 20, 10, 1'b0);  // start line already below the screen
      run_phase(170, 1023, 400, 1, 50, 8, 1'b0);    // reaches the bottom within a few chars
      run_phase(85, 624, 464, 64, 50, 5, 1'b0);
      run_phase($urandom_range(255), $urandom_range(1023), $urandom_range(511),
                $urandom_range(64, 1), 70, 4, 1'b1);
      run_phase($urandom_range(255), $urandom_range(1023), $urandom_range(511),
                $urandom_range(64, 1), 60, 6, 1'b0);
      run_phase($urandom_range(255), 0, 0, 64, 20, 2, 1'b0);

      drain_and_settle();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // driver: offers queued transactions, predicts each one as it is accepted
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            bus_req.mode      = req_bus.mode;
            bus_req.row_index = req_bus.font_row_index;
            bus_req.row_bits  = req_bus.font_row_bits;
            bus_req.first     = req_bus.code_first;
            bus_req.second    = req_bus.code_second;
            render_request(bus_req);
         end
         // random gaps between transactions, none in the steady phase
         if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_req = pending_reqs.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.mode           <= next_req.mode;
            req_bus.font_row_index <= next_req.row_index;
            req_bus.font_row_bits  <= next_req.row_bits;
            req_bus.code_first     <= next_req.first;
            req_bus.code_second    <= next_req.second;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: every accepted row write against the oldest owed one
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_write.offset = rsp_bus.pixel_offset;
         seen_write.mask   = rsp_bus.pixel_mask;
         seen_write.color  = rsp_bus.pixel_color;
         seen_write.last   = rsp_bus.last_row;
         if (owed_writes.size() == 0) begin
            $error("unexpected row write: offset %0d mask %h", seen_write.offset,
                   seen_write.mask);
            failures++;
         end else begin
            want_write = owed_writes.pop_front();
            if (seen_write.offset !== want_write.offset) begin
               $error("pixel_offset: expected %0d, got %0d", want_write.offset,
                      seen_write.offset);
               failures++;
            end
            if (seen_write.mask !== want_write.mask) begin
               $error("pixel_mask: expected %h, got %h", want_write.mask, seen_write.mask);
               failures++;
            end
            if (seen_write.color !== want_write.color) begin
               $error("pixel_color: expected %0d, got %0d", want_write.color,
                      seen_write.color);
               failures++;
            end
            if (seen_write.last !== want_write.last) begin
               $error("last_row: expected %0d, got %0d", want_write.last, seen_write.last);
               failures++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
